[sv/qrsbe_pkg.sv]
package qrsbe_pkg;

	localparam int SYMBOL_W = 16;
	localparam int VALUE_W  = 16;
	localparam int WIDTH_W  = 5;
	localparam int GROUP_W  = 10;
	localparam int FILL_W   = 2;
	localparam int VER_W    = 6;
	localparam int LEN_W    = 13;
	localparam int CFG_IDX_W = 2;
	localparam int RES_SLOTS = 3;
	localparam int ALNUM_N  = 45;

	typedef enum logic [1:0] {
		MODE_NUMERIC,
		MODE_ALNUM,
		MODE_BYTE,
		MODE_KANJI
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE,
		CFG_VERSION,
		CFG_LENGTH
	} cfg_index_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [WIDTH_W-1:0] width;
		logic               bad;
	} res_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] idx;
	} alnum_t;

	localparam logic [7:0] ALNUM_CHARS [ALNUM_N] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
		8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A,
		8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54,
		8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A,
		8'h20, 8'h24, 8'h25, 8'h2A, 8'h2B, 8'h2D, 8'h2E, 8'h2F, 8'h3A
	};

	localparam logic [15:0] KANJI_HI_BASE = 16'hC140;
	localparam logic [15:0] KANJI_LO_BASE = 16'h8140;
	localparam logic [7:0]  KANJI_ROW     = 8'hC0;
	localparam logic [5:0]  ALNUM_RADIX   = 6'd45;
	localparam logic [3:0]  DEC_RADIX     = 4'd10;

	function automatic alnum_t alnum_lookup(input logic [SYMBOL_W-1:0] sym);
		alnum_t r;
		r = '0;
		for (int i = 0; i < ALNUM_N; i++) begin
			if (sym == {8'h00, ALNUM_CHARS[i]}) begin
				r.ok  = 1'b1;
				r.idx = 6'(i);
			end
		end
		return r;
	endfunction

	function automatic logic kanji_ok(input logic [SYMBOL_W-1:0] sym);
		logic [7:0] lead;
		logic [7:0] trail;
		logic       lead_ok;
		logic       trail_ok;
		lead     = sym[15:8];
		trail    = sym[7:0];
		lead_ok  = (lead >= 8'h81 && lead <= 8'h9F) || (lead >= 8'hE0 && lead <= 8'hEB);
		trail_ok = trail >= 8'h40 && trail <= 8'hFC && trail != 8'h7F;
		return lead_ok && trail_ok && !(lead == 8'hEB && trail > 8'hBF);
	endfunction

	function automatic logic [WIDTH_W-1:0] count_width(input mode_t mode,
		input logic [VER_W-1:0] ver);
		logic [1:0] band;
		logic [WIDTH_W-1:0] w;
		band = (ver < 6'd10) ? 2'd0 : ((ver < 6'd27) ? 2'd1 : 2'd2);
		unique case (mode)
			MODE_NUMERIC: w = 5'd10 + {2'b00, band, 1'b0};
			MODE_ALNUM:   w = 5'd9 + {2'b00, band, 1'b0};
			MODE_BYTE:    w = (band == 2'd0) ? 5'd8 : 5'd16;
			MODE_KANJI:   w = 5'd8 + {2'b00, band, 1'b0};
		endcase
		return w;
	endfunction

	function automatic logic [VALUE_W-1:0] mask_to(input logic [VALUE_W-1:0] v,
		input logic [WIDTH_W-1:0] w);
		logic [VALUE_W:0] m;
		m = (17'd1 << w) - 17'd1;
		return v & m[VALUE_W-1:0];
	endfunction

endpackage

[sv/qr_segment_bit_encoder.sv]
// QR data segment bit encoder. Each request carries one character (digit, alphanumeric
// character, Latin-1 byte or Shift-JIS word, per encoding_mode) and yields zero to three
// right-aligned bit chunks, sent most significant bit first. The first character of a
// message is preceded by the 4-bit mode indicator and the character count indicator;
// a request with last_symbol set flushes a partial numeric or alphanumeric group and
// ends the message. An unencodable character yields one chunk of width 0 with
// bad_symbol set. Requests go through an input register and a three-entry result
// register; the result port drains one chunk per cycle while out_ready is high, and a
// request that yields several chunks holds the input side until its last chunk is
// taken. Configuration is to be written by the user only while the block is idle
// (the block itself does not enforce this) and takes effect on the next request.
module qr_segment_bit_encoder (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_we,
	input  logic [qrsbe_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [qrsbe_pkg::LEN_W-1:0]              cfg_data,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic [qrsbe_pkg::SYMBOL_W-1:0]           symbol,
	input  logic                                     last_symbol,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic [qrsbe_pkg::VALUE_W-1:0]            chunk_value,
	output logic [qrsbe_pkg::WIDTH_W-1:0]            chunk_width,
	output logic                                     bad_symbol,
	output logic                                     last_chunk
);

	qrsbe_pkg::mode_t                      mode_q;
	logic [qrsbe_pkg::VER_W-1:0]           version_q;
	logic [qrsbe_pkg::LEN_W-1:0]           length_q;
	logic [qrsbe_pkg::GROUP_W-1:0]         group_value_q;
	logic [qrsbe_pkg::FILL_W-1:0]          group_fill_q;
	logic                                  header_sent_q;

	logic                                  valid_s1;
	logic [qrsbe_pkg::SYMBOL_W-1:0]        symbol_s1;
	logic                                  last_s1;

	qrsbe_pkg::res_t                       res_q [qrsbe_pkg::RES_SLOTS];
	logic [1:0]                            rem_q;

	logic                                  load;
	logic                                  pop;

	qrsbe_pkg::res_t                       slot_n [qrsbe_pkg::RES_SLOTS];
	logic [1:0]                            count_n;
	logic [qrsbe_pkg::GROUP_W-1:0]         value_n;
	logic [qrsbe_pkg::FILL_W-1:0]          fill_n;

	assign load      = valid_s1 && (rem_q == 2'd0 || (rem_q == 2'd1 && out_ready));
	assign in_ready  = !valid_s1 || load;
	assign out_valid = rem_q != 2'd0;
	assign pop       = out_valid && out_ready;

	assign chunk_value = res_q[0].value;
	assign chunk_width = res_q[0].width;
	assign bad_symbol  = res_q[0].bad;
	assign last_chunk  = rem_q == 2'd1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= qrsbe_pkg::MODE_NUMERIC;
			version_q <= 6'd1;
			length_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				qrsbe_pkg::CFG_MODE:    mode_q    <= qrsbe_pkg::mode_t'(cfg_data[1:0]);
				qrsbe_pkg::CFG_VERSION: version_q <= cfg_data[qrsbe_pkg::VER_W-1:0];
				qrsbe_pkg::CFG_LENGTH:  length_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			symbol_s1 <= symbol;
			last_s1   <= last_symbol;
		end
	end

	// encoding
	always_comb begin
		logic                            hdr;
		logic                            main_en;
		logic                            flush_en;
		qrsbe_pkg::res_t                 main_r;
		qrsbe_pkg::res_t                 flush_r;
		qrsbe_pkg::res_t                 hdr_mode_r;
		qrsbe_pkg::res_t                 hdr_count_r;
		qrsbe_pkg::alnum_t               an;
		logic [13:0]                     num_sum;
		logic [15:0]                     pair;
		logic [15:0]                     kw;
		logic [15:0]                     kv;
		logic [2:0]                      fill_inc;
		logic [qrsbe_pkg::WIDTH_W-1:0]   cw;
		logic [qrsbe_pkg::WIDTH_W-1:0]   fw;

		hdr      = !header_sent_q;
		main_en  = 1'b0;
		flush_en = 1'b0;
		main_r   = '{value: '0, width: '0, bad: 1'b1};
		flush_r  = '0;
		value_n  = group_value_q;
		fill_n   = group_fill_q;
		an       = qrsbe_pkg::alnum_lookup(symbol_s1);
		num_sum  = {4'b0, group_value_q} * {10'b0, qrsbe_pkg::DEC_RADIX}
			+ {10'b0, symbol_s1[3:0]};
		pair     = {6'b0, group_value_q} * {10'b0, qrsbe_pkg::ALNUM_RADIX}
			+ {10'b0, an.idx};
		kw       = symbol_s1 - ((symbol_s1 >= qrsbe_pkg::KANJI_HI_BASE)
			? qrsbe_pkg::KANJI_HI_BASE : qrsbe_pkg::KANJI_LO_BASE);
		kv       = {8'b0, kw[15:8]} * {8'b0, qrsbe_pkg::KANJI_ROW} + {8'b0, kw[7:0]};
		fill_inc = {1'b0, group_fill_q} + 3'd1;

		unique case (mode_q)
			qrsbe_pkg::MODE_NUMERIC: begin
				if (symbol_s1 >= 16'h0030 && symbol_s1 <= 16'h0039) begin
					if (fill_inc >= 3'd3) begin
						main_en = 1'b1;
						main_r  = '{value: {6'b0, num_sum[9:0]}, width: 5'd10, bad: 1'b0};
						value_n = '0;
						fill_n  = '0;
					end else begin
						value_n = num_sum[9:0];
						fill_n  = fill_inc[1:0];
					end
				end else begin
					main_en = 1'b1;
				end
			end
			qrsbe_pkg::MODE_ALNUM: begin
				if (an.ok) begin
					if (group_fill_q == 2'd0) begin
						value_n = {4'b0, an.idx};
						fill_n  = 2'd1;
					end else begin
						main_en = 1'b1;
						main_r  = '{value: {5'b0, pair[10:0]}, width: 5'd11, bad: 1'b0};
						value_n = '0;
						fill_n  = '0;
					end
				end else begin
					main_en = 1'b1;
				end
			end
			qrsbe_pkg::MODE_BYTE: begin
				main_en = 1'b1;
				if (symbol_s1[15:8] == 8'h00)
					main_r = '{value: symbol_s1, width: 5'd8, bad: 1'b0};
			end
			qrsbe_pkg::MODE_KANJI: begin
				main_en = 1'b1;
				if (qrsbe_pkg::kanji_ok(symbol_s1))
					main_r = '{value: {3'b0, kv[12:0]}, width: 5'd13, bad: 1'b0};
			end
		endcase

		// flush of a partial group
		fw = {1'b0, fill_n, 2'b00} - {3'b0, fill_n} + 5'd1;
		if (last_s1) begin
			if (fill_n != 2'd0) begin
				if (mode_q == qrsbe_pkg::MODE_NUMERIC) begin
					flush_en = 1'b1;
					flush_r  = '{value: qrsbe_pkg::mask_to({6'b0, value_n}, fw),
						width: fw, bad: 1'b0};
				end else if (mode_q == qrsbe_pkg::MODE_ALNUM) begin
					flush_en = 1'b1;
					flush_r  = '{value: {10'b0, value_n[5:0]}, width: 5'd6, bad: 1'b0};
				end
			end
			value_n = '0;
			fill_n  = '0;
		end

		cw          = qrsbe_pkg::count_width(mode_q, version_q);
		hdr_mode_r  = '{value: 16'd1 << mode_q, width: 5'd4, bad: 1'b0};
		hdr_count_r = '{value: qrsbe_pkg::mask_to({3'b0, length_q}, cw), width: cw,
			bad: 1'b0};

		slot_n[0] = hdr ? hdr_mode_r : (main_en ? main_r : flush_r);
		slot_n[1] = hdr ? hdr_count_r : flush_r;
		slot_n[2] = main_en ? main_r : flush_r;
		count_n   = (hdr ? 2'd2 : 2'd0) + {1'b0, main_en} + {1'b0, flush_en};
	end

	// encoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_value_q <= '0;
			group_fill_q  <= '0;
			header_sent_q <= 1'b0;
		end else if (load) begin
			group_value_q <= value_n;
			group_fill_q  <= fill_n;
			header_sent_q <= !last_s1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= count_n;
		end else if (pop) begin
			rem_q <= rem_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= slot_n;
		end else if (pop) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

endmodule

[sv/qrsbe_checker.sv]
module qrsbe_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [qrsbe_pkg::VALUE_W-1:0]       chunk_value,
	input logic [qrsbe_pkg::WIDTH_W-1:0]       chunk_width,
	input logic                                bad_symbol,
	input logic                                last_chunk
);

	// stalled chunk holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(chunk_value)
			&& $stable(chunk_width) && $stable(bad_symbol) && $stable(last_chunk))
		else $error("stalled chunk changed");

	// bad marker is an empty chunk
	a_bad_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_symbol |-> chunk_width == 5'd0 && chunk_value == '0)
		else $error("bad marker carries bits");

	// real chunks have bits and fit their width
	a_width_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !bad_symbol |-> chunk_width != 5'd0 && chunk_width <= 5'd16
			&& (chunk_value >> chunk_width) == '0)
		else $error("chunk value exceeds width");

	// a stalled chunk that is not the last of its request holds, so no new request overwrites it
	a_accept_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_chunk && $past(out_valid && !last_chunk) && !$past(out_ready)
			|-> $stable(chunk_value))
		else $error("multi chunk request lost order");

endmodule

bind qr_segment_bit_encoder qrsbe_checker u_qrsbe_checker (.*);
